// ----- hw/rtl/egcd_pkg.sv -----
// Shared types and constants for the extended Euclidean gcd / modular inverse core.
// Holds the controller state type and the controller-to-datapath command and status structs.
// No dependencies.
package egcd_pkg;

  // Default operand width in bits.
  localparam int OPERAND_WIDTH_DEF = 32;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_REDUCE,
    ST_DONE
  } egcd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // Capture a new item and initialize the coefficients.
    logic div_start;  // Prime the divider with r0 / r1.
    logic div_step;   // One restoring division step.
    logic update;     // Rotate remainders and coefficients.
    logic reduce;     // Reduce |x| against the modulus.
    logic out_load;   // Move the finished result into the output register.
  } egcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic r1_zero;    // Current divisor is zero, so the loop ends.
    logic div_last;   // The divider is on its last step.
  } egcd_status_t;

endpackage

// ----- hw/rtl/egcd_if.sv -----
// Valid/ready channel interfaces for the gcd core input and result items.
// Depends on egcd_pkg for the default operand width.
interface egcd_in_if #(parameter int W = egcd_pkg::OPERAND_WIDTH_DEF);
  logic         valid;
  logic         ready;
  logic [W-1:0] value_a;
  logic [W-1:0] modulus;

  modport source (output valid, output value_a, output modulus, input ready);
  modport sink (input valid, input value_a, input modulus, output ready);
endinterface

interface egcd_out_if #(parameter int W = egcd_pkg::OPERAND_WIDTH_DEF);
  logic              valid;
  logic              ready;
  logic [W-1:0]      gcd_value;
  logic signed [W:0] coef_x;
  logic signed [W:0] coef_y;
  logic [W-1:0]      inverse;
  logic              inverse_valid;

  modport source (output valid, output gcd_value, output coef_x, output coef_y,
                  output inverse, output inverse_valid, input ready);
  modport sink (input valid, input gcd_value, input coef_x, input coef_y,
                input inverse, input inverse_valid, output ready);
endinterface

// ----- hw/rtl/extended_gcd_mod_inverse_core.sv -----
// Top level of the extended Euclidean gcd and modular inverse core.
// Depends on egcd_pkg, egcd_if, egcd_ctrl and egcd_datapath.
//
//   channel   direction  fields
//   in_ch     sink       value_a, modulus
//   out_ch    source     gcd_value, coef_x, coef_y, inverse, inverse_valid
//
// Each Euclid division step runs through the shared divider, which yields one quotient
// bit per cycle. One item is in work at a time; the next is accepted while the previous
// result still waits in the output register. Reset is synchronous and leaves the core
// idle with no result pending. A stalled result holds the core before handoff.
module extended_gcd_mod_inverse_core #(
  parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  egcd_in_if.sink    in_ch,
  egcd_out_if.source out_ch
);
  import egcd_pkg::*;

  egcd_cmd_t    cmd;
  egcd_status_t status;

  egcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  egcd_datapath #(
    .W (OPERAND_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .in_value_a    (in_ch.value_a),
    .in_modulus    (in_ch.modulus),
    .cmd           (cmd),
    .status        (status),
    .gcd_value     (out_ch.gcd_value),
    .coef_x        (out_ch.coef_x),
    .coef_y        (out_ch.coef_y),
    .inverse       (out_ch.inverse),
    .inverse_valid (out_ch.inverse_valid)
  );

`ifndef SYNTHESIS
  // An accepted item is always captured by the datapath.
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |-> cmd.load)
    else $error("accepted item not loaded");

  // A handoff into the output register always raises the result valid.
  a_handoff_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_ch.valid)
    else $error("result handoff lost");

  // A valid inverse implies a gcd of one.
  a_inv_gcd_one: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.inverse_valid) |-> (out_ch.gcd_value == OPERAND_WIDTH'(1)))
    else $error("valid inverse with gcd other than one");

  // An invalid inverse reads as zero.
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.inverse_valid) |-> (out_ch.inverse == '0))
    else $error("invalid inverse is not zero");
`endif

endmodule

// ----- hw/rtl/egcd_datapath.sv -----
// Datapath of the gcd core: remainders, Bezout coefficients, a bit-serial divider
// with quotient-times-coefficient accumulators, the inverse reduction and the output register.
// Depends on egcd_pkg.
module egcd_datapath #(
  parameter int W = egcd_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic [W-1:0]            in_value_a,
  input  logic [W-1:0]            in_modulus,
  input  egcd_pkg::egcd_cmd_t     cmd,
  output egcd_pkg::egcd_status_t  status,
  output logic [W-1:0]            gcd_value,
  output logic [W:0]              coef_x,
  output logic [W:0]              coef_y,
  output logic [W-1:0]            inverse,
  output logic                    inverse_valid
);
  import egcd_pkg::*;

  localparam int CNT_W = $clog2(W);

  // Euclid state; coefficients are kept modulo 2^(W+1), where their true values fit.
  logic [W-1:0]     r0;
  logic [W-1:0]     r1;
  logic [W-1:0]     m;
  logic [W:0]       s0;
  logic [W:0]       s1;
  logic [W:0]       t0;
  logic [W:0]       t1;

  // Divider state.
  logic [W-1:0]     dq;
  logic [W-1:0]     drem;
  logic [W:0]       acc_s;
  logic [W:0]       acc_t;
  logic [CNT_W-1:0] cnt;

  // Reduction state.
  logic [W-1:0]     red;
  logic             inv_ok;

  logic [W:0]       shifted;
  logic [W+1:0]     trial;
  logic             qbit;
  logic [W-1:0]     drem_next;
  logic [W:0]       acc_s_next;
  logic [W:0]       acc_t_next;
  logic             neg;
  logic [W:0]       mag_full;
  logic [W-1:0]     mag;
  logic [W-1:0]     red_next;
  logic [W-1:0]     inv_result;

  // One restoring division step; the quotient bit also drives the product accumulators.
  always_comb begin
    shifted    = {drem, dq[W-1]};
    trial      = {1'b0, shifted} - {2'b00, r1};
    qbit       = ~trial[W+1];
    drem_next  = qbit ? trial[W-1:0] : shifted[W-1:0];
    acc_s_next = {acc_s[W-1:0], 1'b0} + (qbit ? s1 : '0);
    acc_t_next = {acc_t[W-1:0], 1'b0} + (qbit ? t1 : '0);
  end

  // Magnitude of x reduced once against the modulus; |x| never exceeds the modulus.
  always_comb begin
    neg        = s0[W];
    mag_full   = neg ? (~s0 + 1'b1) : s0;
    mag        = mag_full[W-1:0];
    red_next   = (mag >= m) ? (mag - m) : mag;
    if (!inv_ok) begin
      inv_result = '0;
    end else if (neg && (red != '0)) begin
      inv_result = m - red;
    end else begin
      inv_result = red;
    end
  end

  // Status toward the controller.
  assign status.r1_zero  = (r1 == '0);
  assign status.div_last = (cnt == '0);

  // Euclid registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r0 <= in_value_a;
      r1 <= in_modulus;
      m  <= in_modulus;
      s0 <= (W+1)'(1);
      s1 <= '0;
      t0 <= '0;
      t1 <= (W+1)'(1);
    end else if (cmd.update) begin
      r0 <= r1;
      r1 <= drem;
      s0 <= s1;
      s1 <= s0 - acc_s;
      t0 <= t1;
      t1 <= t0 - acc_t;
    end
  end

  // Divider registers.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq    <= r0;
      drem  <= '0;
      acc_s <= '0;
      acc_t <= '0;
      cnt   <= CNT_W'(W - 1);
    end else if (cmd.div_step) begin
      dq    <= {dq[W-2:0], qbit};
      drem  <= drem_next;
      acc_s <= acc_s_next;
      acc_t <= acc_t_next;
      cnt   <= cnt - 1'b1;
    end
  end

  // Inverse reduction.
  always_ff @(posedge clk) begin
    if (cmd.reduce) begin
      red    <= red_next;
      inv_ok <= (r0 == W'(1)) && (m != '0);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      gcd_value     <= r0;
      coef_x        <= s0;
      coef_y        <= t0;
      inverse       <= inv_result;
      inverse_valid <= inv_ok;
    end
  end

endmodule

// ----- hw/rtl/egcd_ctrl.sv -----
// Controller state machine of the gcd core: sequences load, division, update,
// reduction and result handoff, and owns the channel handshakes.
// Depends on egcd_pkg.
module egcd_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  egcd_pkg::egcd_status_t  status,
  output egcd_pkg::egcd_cmd_t     cmd
);
  import egcd_pkg::*;

  egcd_state_t state;
  egcd_state_t state_next;
  logic        out_valid_next;
  logic        slot_free;

  // The output register can take a result when empty or being drained.
  assign slot_free = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.r1_zero ? ST_REDUCE : ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_CHECK;
      end
      ST_REDUCE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Commands and handshakes.
  always_comb begin
    in_ready      = (state == ST_IDLE);
    cmd           = '0;
    cmd.load      = (state == ST_IDLE) && in_valid;
    cmd.div_start = (state == ST_CHECK) && !status.r1_zero;
    cmd.div_step  = (state == ST_DIV);
    cmd.update    = (state == ST_UPDATE);
    cmd.reduce    = (state == ST_REDUCE);
    cmd.out_load  = (state == ST_DONE) && slot_free;
  end

  // Output valid flag.
  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
